// File: sv/bthalloc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bthalloc_pkg
// Shared types and codes for the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package bthalloc_pkg;

   typedef enum logic [1:0] {
      CMD_INIT        = 2'd0,
      CMD_ALLOC_FIRST = 2'd1,
      CMD_ALLOC_BEST  = 2'd2,
      CMD_FREE        = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NO_FIT  = 2'd1,
      STAT_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_HEAP_BASE = 2'd0,
      CSR_HEAP_SIZE = 2'd1,
      CSR_MIN_BLOCK = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_LO,
      ST_INIT_HI,
      ST_MARK_A_HDR,
      ST_MARK_A_FTR,
      ST_MARK_B_HDR,
      ST_MARK_B_FTR,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_PLACE,
      ST_FREE_PREV_RD,
      ST_FREE_PREV_CHK,
      ST_FREE_NEXT_CHK
   } state_type;

   localparam int TAG_BYTES     = 8;
   localparam int MIN_HEAP      = 16;
   localparam int HEAP_SIZE_RST = 16384;
   localparam int MIN_BLOCK_RST = 8;

endpackage
`default_nettype wire

// File: sv/boundary_tag_heap_allocator_core.sv
`default_nettype none
// Init writes 4 tags. Allocate reads and checks each block tag visited in the chain walk,
//   then places the block and makes 2 or 4 tag writes (plus 4 more if the heap self-inits).
// Free walks the chain, reads the neighbor tags on both sides, then makes 2 tag writes.
// One item at a time through the tag memory; result strobe lasts 1 cycle.
// Reset clears control state and loads config registers with defaults; tag memory holds garbage until init.
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_core
// Boundary-tag heap allocator: first/best fit allocation and coalescing free.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator_core
   import bthalloc_pkg::*;
#(
   parameter int HEAP_BYTES = 16384
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [14:0] req_request_size,
   input  wire logic [31:0] req_block_address,
   output logic             rsp_valid,
   output logic [31:0]      rsp_result_address,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int DEPTH = HEAP_BYTES / 2;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int TAG_W = $clog2(HEAP_BYTES + 1);
   localparam int OFF_W = $clog2(HEAP_BYTES + 1) + 1;
   localparam int CAP   = HEAP_BYTES & ~1;

   // tag memory
   logic [TAG_W-1:0] tag_mem_ff [DEPTH];
   logic [TAG_W-1:0] rd_data_ff;
   logic             wr_en;
   logic [OFF_W-1:0] wr_off;
   logic [TAG_W-1:0] wr_data;
   logic [OFF_W-1:0] rd_off;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem_ff[wr_off[IDX_W:1]] <= wr_data;
      end
      rd_data_ff <= tag_mem_ff[rd_off[IDX_W:1]];
   end

   // config registers
   logic [31:0] heap_base_ff;
   logic [14:0] heap_size_ff;
   logic [8:0]  min_block_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         heap_size_ff <= 15'(HEAP_SIZE_RST);
         min_block_ff <= 9'(MIN_BLOCK_RST);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEAP_BASE: heap_base_ff <= csr_data;
            CSR_HEAP_SIZE: heap_size_ff <= csr_data[14:0];
            CSR_MIN_BLOCK: min_block_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // effective sizes
   logic [15:0] hs_even;
   logic [31:0] eff_s;
   logic [9:0]  eff_m;
   logic [15:0] req_even;
   logic [16:0] req_need;

   always_comb begin
      hs_even = 16'(heap_size_ff) + 16'(heap_size_ff[0]);
      if (32'(hs_even) < 32'(MIN_HEAP)) begin
         eff_s = 32'(MIN_HEAP);
      end else if (32'(hs_even) > 32'(CAP)) begin
         eff_s = 32'(CAP);
      end else begin
         eff_s = 32'(hs_even);
      end
      eff_m = 10'(min_block_ff) + 10'(min_block_ff[0]);
      if (eff_m < 10'd2) begin
         eff_m = 10'd2;
      end
      req_even = 16'(req_request_size) + 16'(req_request_size[0]);
      if (req_even < 16'(eff_m)) begin
         req_need = 17'(eff_m) + 17'(TAG_BYTES);
      end else begin
         req_need = 17'(req_even) + 17'(TAG_BYTES);
      end
   end

   // control
   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic             heap_ready_ff, heap_ready_in;
   logic             in_init_ff, in_init_in;
   logic             found_ff, found_in;
   logic             two_ff, two_in;
   logic             next_oob_ff, next_oob_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_addr_ff, rsp_addr_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [16:0]      need_ff, need_in;
   logic [31:0]      off_ff, off_in;
   logic [OFF_W-1:0] h_ff, h_in;
   logic [OFF_W-1:0] pick_ff, pick_in;
   logic [TAG_W-1:0] pick_sz_ff, pick_sz_in;
   logic [TAG_W-1:0] blk_sz_ff, blk_sz_in;
   logic [OFF_W-1:0] init_s_ff, init_s_in;
   logic [OFF_W-1:0] mark_a_ff, mark_a_in;
   logic [TAG_W-1:0] mark_sa_ff, mark_sa_in;
   logic             mark_ua_ff, mark_ua_in;
   logic [OFF_W-1:0] mark_b_ff, mark_b_in;
   logic [TAG_W-1:0] mark_sb_ff, mark_sb_in;

   logic [TAG_W-1:0] rd_sz;
   logic [31:0]      rem;
   logic [31:0]      alloc_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         heap_ready_ff <= 1'b0;
         in_init_ff    <= 1'b0;
         found_ff      <= 1'b0;
         two_ff        <= 1'b0;
         next_oob_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cmd_ff        <= CMD_INIT;
      end else begin
         state_ff      <= state_in;
         heap_ready_ff <= heap_ready_in;
         in_init_ff    <= in_init_in;
         found_ff      <= found_in;
         two_ff        <= two_in;
         next_oob_ff   <= next_oob_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmd_ff        <= cmd_in;
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      need_ff       <= need_in;
      off_ff        <= off_in;
      h_ff          <= h_in;
      pick_ff       <= pick_in;
      pick_sz_ff    <= pick_sz_in;
      blk_sz_ff     <= blk_sz_in;
      init_s_ff     <= init_s_in;
      mark_a_ff     <= mark_a_in;
      mark_sa_ff    <= mark_sa_in;
      mark_ua_ff    <= mark_ua_in;
      mark_b_ff     <= mark_b_in;
      mark_sb_ff    <= mark_sb_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      heap_ready_in = heap_ready_ff;
      in_init_in    = in_init_ff;
      found_in      = found_ff;
      two_in        = two_ff;
      next_oob_in   = next_oob_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      need_in       = need_ff;
      off_in        = off_ff;
      h_in          = h_ff;
      pick_in       = pick_ff;
      pick_sz_in    = pick_sz_ff;
      blk_sz_in     = blk_sz_ff;
      init_s_in     = init_s_ff;
      mark_a_in     = mark_a_ff;
      mark_sa_in    = mark_sa_ff;
      mark_ua_in    = mark_ua_ff;
      mark_b_in     = mark_b_ff;
      mark_sb_in    = mark_sb_ff;
      wr_en         = 1'b0;
      wr_off        = '0;
      wr_data       = '0;
      rd_off        = h_ff;
      rd_sz         = {rd_data_ff[TAG_W-1:1], 1'b0};
      rem           = 32'(pick_sz_ff) - 32'(need_ff);
      alloc_addr    = heap_base_ff + 32'(mark_a_ff) + 32'd4;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in     = cmd_type'(req_command);
               need_in    = req_need;
               off_in     = req_block_address - heap_base_ff;
               h_in       = OFF_W'(4);
               found_in   = 1'b0;
               in_init_in = 1'b0;
               if (req_command == CMD_INIT ||
                   (req_command != CMD_FREE && !heap_ready_ff)) begin
                  in_init_in    = 1'b1;
                  heap_ready_in = 1'b1;
                  init_s_in     = OFF_W'(eff_s);
                  mark_a_in     = OFF_W'(4);
                  mark_sa_in    = TAG_W'(eff_s - 32'(TAG_BYTES));
                  mark_ua_in    = 1'b0;
                  two_in        = 1'b0;
                  state_in      = ST_INIT_LO;
               end else if (req_command == CMD_FREE &&
                            (req_block_address == '0 || !heap_ready_ff)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = STAT_INVALID;
               end else begin
                  state_in = ST_WALK_RD;
               end
            end
         end
         ST_INIT_LO: begin
            wr_en    = 1'b1;
            wr_off   = '0;
            wr_data  = TAG_W'(1);
            state_in = ST_INIT_HI;
         end
         ST_INIT_HI: begin
            wr_en    = 1'b1;
            wr_off   = init_s_ff - OFF_W'(4);
            wr_data  = TAG_W'(1);
            state_in = ST_MARK_A_HDR;
         end
         ST_MARK_A_HDR: begin
            wr_en    = 1'b1;
            wr_off   = mark_a_ff;
            wr_data  = {mark_sa_ff[TAG_W-1:1], mark_ua_ff};
            state_in = ST_MARK_A_FTR;
         end
         ST_MARK_A_FTR: begin
            wr_en   = 1'b1;
            wr_off  = OFF_W'(32'(mark_a_ff) + 32'(mark_sa_ff) - 32'd4);
            wr_data = {mark_sa_ff[TAG_W-1:1], mark_ua_ff};
            if (two_ff) begin
               state_in = ST_MARK_B_HDR;
            end else if (in_init_ff && cmd_ff != CMD_INIT) begin
               // heap set up on demand; now run the allocation
               in_init_in = 1'b0;
               h_in       = OFF_W'(4);
               found_in   = 1'b0;
               state_in   = ST_WALK_RD;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_addr_in   = (cmd_ff == CMD_ALLOC_FIRST || cmd_ff == CMD_ALLOC_BEST)
                               ? alloc_addr : 32'd0;
               state_in      = ST_IDLE;
            end
         end
         ST_MARK_B_HDR: begin
            wr_en    = 1'b1;
            wr_off   = mark_b_ff;
            wr_data  = mark_sb_ff;
            state_in = ST_MARK_B_FTR;
         end
         ST_MARK_B_FTR: begin
            wr_en         = 1'b1;
            wr_off        = OFF_W'(32'(mark_b_ff) + 32'(mark_sb_ff) - 32'd4);
            wr_data       = mark_sb_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_addr_in   = alloc_addr;
            state_in      = ST_IDLE;
         end
         ST_WALK_RD: begin
            rd_off = h_ff;
            if (32'(h_ff) >= 32'(HEAP_BYTES)) begin
               if (cmd_ff == CMD_FREE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = STAT_INVALID;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_PLACE;
               end
            end else begin
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            if (rd_sz == '0) begin
               // end sentinel
               if (cmd_ff == CMD_FREE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = STAT_INVALID;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_PLACE;
               end
            end else if (cmd_ff == CMD_FREE) begin
               if (32'(h_ff) + 32'd4 == off_ff) begin
                  if (rd_data_ff[0]) begin
                     blk_sz_in  = rd_sz;
                     mark_a_in  = h_ff;
                     mark_sa_in = rd_sz;
                     mark_ua_in = 1'b0;
                     two_in     = 1'b0;
                     state_in   = ST_FREE_PREV_RD;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_addr_in   = '0;
                     rsp_status_in = STAT_INVALID;
                     state_in      = ST_IDLE;
                  end
               end else if (32'(h_ff) + 32'd4 > off_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = STAT_INVALID;
                  state_in      = ST_IDLE;
               end else begin
                  h_in     = OFF_W'(32'(h_ff) + 32'(rd_sz));
                  state_in = ST_WALK_RD;
               end
            end else begin
               h_in     = OFF_W'(32'(h_ff) + 32'(rd_sz));
               state_in = ST_WALK_RD;
               if (!rd_data_ff[0] && 32'(rd_sz) >= 32'(need_ff) &&
                   (!found_ff || (cmd_ff == CMD_ALLOC_BEST && rd_sz < pick_sz_ff))) begin
                  pick_in    = h_ff;
                  pick_sz_in = rd_sz;
                  found_in   = 1'b1;
                  if (cmd_ff == CMD_ALLOC_FIRST) begin
                     state_in = ST_PLACE;
                  end
               end
            end
         end
         ST_PLACE: begin
            if (!found_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STAT_NO_FIT;
               state_in      = ST_IDLE;
            end else begin
               mark_a_in  = pick_ff;
               mark_ua_in = 1'b1;
               in_init_in = 1'b0;
               state_in   = ST_MARK_A_HDR;
               if (rem < 32'(eff_m) * 32'd2) begin
                  mark_sa_in = pick_sz_ff;
                  two_in     = 1'b0;
               end else begin
                  mark_sa_in = TAG_W'(need_ff);
                  mark_b_in  = OFF_W'(32'(pick_ff) + 32'(need_ff));
                  mark_sb_in = TAG_W'(rem);
                  two_in     = 1'b1;
               end
            end
         end
         ST_FREE_PREV_RD: begin
            rd_off   = h_ff - OFF_W'(4);
            state_in = ST_FREE_PREV_CHK;
         end
         ST_FREE_PREV_CHK: begin
            if (rd_sz != '0 && !rd_data_ff[0]) begin
               mark_a_in  = h_ff - OFF_W'(rd_sz);
               mark_sa_in = mark_sa_ff + rd_sz;
            end
            rd_off      = OFF_W'(32'(h_ff) + 32'(blk_sz_ff));
            next_oob_in = (32'(h_ff) + 32'(blk_sz_ff)) >= 32'(HEAP_BYTES);
            state_in    = ST_FREE_NEXT_CHK;
         end
         ST_FREE_NEXT_CHK: begin
            if (!next_oob_ff && rd_sz != '0 && !rd_data_ff[0]) begin
               mark_sa_in = mark_sa_ff + rd_sz;
            end
            state_in = ST_MARK_A_HDR;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

endmodule
`default_nettype wire

// File: sv/bthalloc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bthalloc_checker
// Port-level checks for the heap allocator core.
// ----------------------------------------------------------------------------
module bthalloc_checker
   import bthalloc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_result_address,
   input wire logic [1:0]  rsp_status
);

   // result strobe only fires while the core is idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_NO_FIT ||
                     rsp_status == STAT_INVALID))
      else $error("bad status code");

   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_result_address == 32'd0)
      else $error("failed item returned an address");

   // busy only rises after an accepted item
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      busy && !$past(busy) |-> $past(start))
      else $error("busy without start");

endmodule

bind boundary_tag_heap_allocator_core bthalloc_checker u_bthalloc_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_result_address (rsp_result_address),
   .rsp_status         (rsp_status)
);
`default_nettype wire
